// ===== design/stack_blur_line_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stack blur line filter.
// Simulation builds get the checks and synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef STACK_BLUR_LINE_ASSERT_SVH
`define STACK_BLUR_LINE_ASSERT_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define SBL_ASSERT_HOLDS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("stack blur line assertion failed");
// The condition pre at one edge requires post at the next edge.
`define SBL_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("stack blur line assertion failed");
`else
`define SBL_ASSERT_HOLDS(lbl, clk, rst, cond)
`define SBL_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// ===== design/sbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbl_pkg
// Types and constants shared by the stack blur line filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbl_pkg;

  localparam int PIX_W = 8;
  localparam int WSUM_W = 18;
  localparam int ISUM_W = 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CALC,
    ST_DIV,
    ST_EMIT
  } state_t;

  // INIT: first pixel of a line, GROW: filling the right half, SLIDE: steady.
  typedef enum logic [1:0] {
    PH_INIT,
    PH_GROW,
    PH_SLIDE
  } phase_t;

  typedef struct packed {
    logic        calc;
    phase_t      phase;
    logic [5:0]  wgt;
    logic [9:0]  tri_k;
    logic [5:0]  r1;
    logic        step;
    logic [2:0]  dbit;
    logic [10:0] ds;
  } lane_ctl_t;

endpackage

// ===== design/sbl_lane.sv =====
// ----------------------------------------------------------------------------
// sbl_lane
// One color channel: running weighted, incoming and outgoing sums, and a
// restoring divider that yields the 8-bit quotient one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbl_lane (
  input  logic               clk,
  input  logic               rst,
  input  sbl_pkg::lane_ctl_t ctl,
  input  logic [7:0]         v,
  input  logic [7:0]         m,
  input  logic [7:0]         d,
  output logic [7:0]         quo
);
  import sbl_pkg::*;

  logic [WSUM_W-1:0] wsum, wsum_next;
  logic [ISUM_W-1:0] isum, isum_next;
  logic [ISUM_W-1:0] osum, osum_next;
  logic [WSUM_W-1:0] rem;
  logic [WSUM_W-1:0] trial;
  logic [WSUM_W:0]   slide_w;

  assign slide_w = (WSUM_W+1)'(wsum) + (WSUM_W+1)'(isum) + (WSUM_W+1)'(v)
                 - (WSUM_W+1)'(osum);
  assign trial = WSUM_W'(ctl.ds) << ctl.dbit;

  always_comb begin
    wsum_next = wsum;
    isum_next = isum;
    osum_next = osum;
    unique case (ctl.phase)
      PH_INIT: begin
        wsum_next = WSUM_W'({10'd0, v} * {8'd0, ctl.tri_k});
        osum_next = ISUM_W'({5'd0, v} * {7'd0, ctl.r1});
        isum_next = '0;
      end
      PH_GROW: begin
        wsum_next = wsum + WSUM_W'({6'd0, v} * {8'd0, ctl.wgt});
        isum_next = isum + ISUM_W'(v);
      end
      PH_SLIDE: begin
        wsum_next = WSUM_W'(slide_w);
        osum_next = osum - ISUM_W'(d) + ISUM_W'(m);
        isum_next = isum + ISUM_W'(v) - ISUM_W'(m);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wsum <= '0;
      isum <= '0;
      osum <= '0;
    end else if (ctl.calc) begin
      wsum <= wsum_next;
      isum <= isum_next;
      osum <= osum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      rem <= wsum_next;
      quo <= '0;
    end else if (ctl.step && rem >= trial) begin
      rem <= rem - trial;
      quo[ctl.dbit] <= 1'b1;
    end
  end

endmodule

// ===== design/sbl_merge.sv =====
// ----------------------------------------------------------------------------
// sbl_merge
// Gathers the lane quotients, or the centre pixel's alpha when alpha blur is off,
// into one output item, and holds it in the output register until taken downstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbl_merge (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] red_q,
  input  logic [7:0] green_q,
  input  logic [7:0] blue_q,
  input  logic [7:0] alpha_q,
  input  logic [7:0] mid_alpha,
  input  logic       line_alpha,
  input  logic       last,
  output logic       free,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic       m_tlast     // line_done
);
  import sbl_pkg::*;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(line_alpha ? alpha_q : mid_alpha), blue_q, green_q, red_q};
      m_tlast <= last;
    end
  end

endmodule

// ===== design/stack_blur_line.sv =====
// An accepted item passes through the read and calc states and, when it completes a
// pixel, the restoring divide in the channel lanes and the emit state, which waits
// for a free output register; at the line end each further owed position is flushed
// the same way. A new item is accepted only in the idle state, after the previous
// one is through, so items do not overlap.
// Reset: synchronous, active high; radius returns to 1 and alpha blurring is off.
// ----------------------------------------------------------------------------
// stack_blur_line
// One-dimensional stack blur of RGBA pixels with four parallel channel lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_blur_line #(
  parameter int MAX_RADIUS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic        m_tlast,   // line_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbl_pkg::*;

  localparam int ER = (MAX_RADIUS < 31) ? MAX_RADIUS : 31;
  localparam int DEPTH = 2 * ER + 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SEEN_CAP = 2 * ER + 2;
  localparam int SW = $clog2(SEEN_CAP + 1);
  localparam int OW = $clog2(ER + 2);
  localparam logic [4:0] ER5 = 5'(ER);

  logic [4:0]  radius;
  logic        alpha_en;
  logic [4:0]  cfg_r;
  logic [5:0]  cfg_r1, cfg_r2;
  logic [9:0]  cfg_tri;
  logic [10:0] cfg_ds;

  logic [4:0]  line_r;
  logic        line_alpha;
  logic [9:0]  line_tri;
  logic [10:0] line_ds;

  state_t state, state_next;
  phase_t phase;
  logic [31:0] pix, first_px, rd_mid, rd_drop, centre, dropped;
  logic        end_flag;
  logic        line_last;
  logic [7:0]  mid_alpha;
  logic [SW-1:0] seen;
  logic [OW-1:0] owed;
  logic [AW-1:0] head, tail, head_n, tail_n, last_slot, grow_slot;
  logic [2:0]  dbit;
  logic        due, out_free, load;
  logic [31:0] win_mem [DEPTH];
  lane_ctl_t   ctl;
  logic [7:0]  quo [4];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'd0, alpha_en} : {27'd0, radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 5'd1;
      alpha_en <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        alpha_en <= pwdata[0];
      end else begin
        radius <= pwdata[4:0];
      end
    end
  end

  assign cfg_r = (radius > ER5) ? ER5 : radius;
  assign cfg_r1 = {1'b0, cfg_r} + 6'd1;
  assign cfg_r2 = cfg_r1 + 6'd1;

  always_ff @(posedge clk) begin
    cfg_tri <= 10'(({6'd0, cfg_r1} * {6'd0, cfg_r2}) >> 1);
    cfg_ds <= 11'({5'd0, cfg_r1} * {5'd0, cfg_r1});
  end

  // Window pointers and phase.
  assign last_slot = AW'({line_r, 1'b0});
  assign head_n = (head == last_slot) ? '0 : head + AW'(1);
  assign tail_n = (tail == last_slot) ? '0 : tail + AW'(1);
  assign grow_slot = AW'(6'(seen) + {1'b0, line_r});
  assign due = 8'(seen) >= 8'(line_r);

  always_comb begin
    if (seen == '0) begin
      phase = PH_INIT;
    end else if (8'(seen) <= 8'(line_r)) begin
      phase = PH_GROW;
    end else begin
      phase = PH_SLIDE;
    end
  end

  // Slots that still hold the first pixel are never written for it.
  assign dropped = (8'(seen) <= 8'({line_r, 1'b1})) ? first_px : rd_drop;
  assign centre = (line_r == '0) ? pix : rd_mid;

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      rd_mid <= win_mem[head_n];
      rd_drop <= win_mem[tail_n];
    end
    if (state == ST_CALC) begin
      if (phase == PH_GROW) begin
        win_mem[grow_slot] <= pix;
      end else if (phase == PH_SLIDE) begin
        win_mem[tail] <= pix;
      end
    end
  end

  // Sequencer.
  assign s_tready = (state == ST_IDLE);
  assign load = (state == ST_EMIT) && out_free;
  assign line_last = end_flag && owed == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_RD;
      ST_RD: state_next = ST_CALC;
      ST_CALC: begin
        if (due && owed != '0) begin
          state_next = ST_DIV;
        end else if (end_flag && owed != '0) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: if (dbit == 3'd0) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (end_flag && owed != '0) ? ST_RD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      owed <= '0;
      head <= '0;
      tail <= '0;
      line_r <= '0;
      line_alpha <= 1'b0;
      end_flag <= 1'b0;
    end else begin
      if (state == ST_IDLE && s_tvalid) begin
        end_flag <= s_tlast;
        owed <= owed + OW'(1);
      end
      if (state == ST_RD) begin
        if (phase == PH_INIT) begin
          line_r <= cfg_r;
          line_alpha <= alpha_en;
        end else if (phase == PH_SLIDE) begin
          head <= head_n;
          tail <= tail_n;
        end
      end
      if (state == ST_CALC) begin
        if (phase == PH_INIT) begin
          head <= AW'(line_r);
          tail <= last_slot;
        end
        if (due && owed != '0) begin
          owed <= owed - OW'(1);
        end
        if (!(due && owed != '0) && end_flag && owed == '0) begin
          seen <= '0;
        end else if (seen != SW'(SEEN_CAP)) begin
          seen <= seen + SW'(1);
        end
      end
      if (load && line_last) begin
        seen <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      pix <= s_tdata;
    end
    if (state == ST_RD && phase == PH_INIT) begin
      line_tri <= cfg_tri;
      line_ds <= cfg_ds;
    end
    if (state == ST_CALC) begin
      unique case (phase)
        PH_INIT: begin
          first_px <= pix;
          mid_alpha <= pix[31:24];
        end
        PH_GROW: mid_alpha <= first_px[31:24];
        default: mid_alpha <= centre[31:24];
      endcase
      dbit <= 3'd7;
    end else if (state == ST_DIV) begin
      dbit <= dbit - 3'd1;
    end
  end

  // Channel lanes.
  always_comb begin
    ctl.calc = (state == ST_CALC);
    ctl.phase = phase;
    ctl.wgt = {1'b0, line_r} + 6'd1 - 6'(seen);
    ctl.tri_k = line_tri;
    ctl.r1 = {1'b0, line_r} + 6'd1;
    ctl.step = (state == ST_DIV);
    ctl.dbit = dbit;
    ctl.ds = line_ds;
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    sbl_lane u_lane (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .v   (pix[8*c +: 8]),
      .m   (centre[8*c +: 8]),
      .d   (dropped[8*c +: 8]),
      .quo (quo[c])
    );
  end

  sbl_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .red_q      (quo[0]),
    .green_q    (quo[1]),
    .blue_q     (quo[2]),
    .alpha_q    (quo[3]),
    .mid_alpha  (mid_alpha),
    .line_alpha (line_alpha),
    .last       (line_last),
    .free       (out_free),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

`include "stack_blur_line_assert.svh"

  `SBL_ASSERT_HOLDS(a_owed_bound, clk, rst, 8'(owed) <= 8'(ER + 1))
  `SBL_ASSERT_NEXT(a_accept_reads, clk, rst, s_tvalid && s_tready, state == ST_RD)
  `SBL_ASSERT_NEXT(a_line_close, clk, rst, load && line_last, seen == '0 && state == ST_IDLE)

endmodule
